// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the encoder's RTL files.
// Has no dependencies; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define HEXE_ASSERT_ALWAYS(label, clk_s, rstn_s, expr) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
		else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define HEXE_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/hexe_pkg.sv =====
// Types, character codes and helper functions for the hex escape encoder.
// No dependencies; the front and back ends, queue, top level and testbench import it.
package hexe_pkg;

	localparam int CAP_W = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] PRINT_LO = 8'h21;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [3:0] DIGIT_LIMIT = 4'hA;

	localparam logic [0:0] FUNC_DATA = 1'b0;
	localparam logic [0:0] FUNC_END = 1'b1;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DONE = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// One queue word: up to three characters, emitted lowest index first.
	typedef struct packed {
		logic [2:0][7:0] chars;
		logic [1:0] num;
		status_t status;
	} hexe_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} hexe_qstat_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < DIGIT_LIMIT) begin
			hex_digit = CH_ZERO + {4'b0000, nib};
		end else begin
			hex_digit = CH_A + {4'b0000, nib - DIGIT_LIMIT};
		end
	endfunction

endpackage

// ===== rtl/hexe_in_if.sv =====
// Input stream channel of the encoder: one byte or end marker per word.
// No dependencies.
interface hexe_in_if;
	logic valid;
	logic ready;
	logic [0:0] func;
	logic [7:0] data_byte;

	modport source(output valid, output func, output data_byte, input ready);
	modport sink(input valid, input func, input data_byte, output ready);
endinterface

// ===== rtl/hexe_out_if.sv =====
// Output stream channel of the encoder: one text character per word.
// No dependencies.
interface hexe_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_char;
	logic out_last;
	logic [1:0] status;

	modport source(output valid, output out_char, output out_last, output status, input ready);
	modport sink(input valid, input out_char, input out_last, input status, output ready);
endinterface

// ===== rtl/hexe_front.sv =====
// Front end: accepts input words, classifies them, keeps the buffer state
// and pushes the characters to emit into the queue. Uses hexe_pkg, hexe_in_if.
module hexe_front import hexe_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	hexe_in_if.sink byte_in,
	input logic [CAP_W-1:0] capacity,
	input hexe_qstat_t q_stat,
	output logic push,
	output hexe_entry_t entry
);

	localparam int SUM_W = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;

	logic hex_mode_q;
	logic overflowed_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic hex_mode_d;
	logic overflowed_d;
	logic [COUNT_WIDTH-1:0] count_d;

	logic accept;
	logic printable;
	logic [COUNT_WIDTH-1:0] count_p1;
	logic [COUNT_WIDTH-1:0] plain_base;
	logic [SUM_W-1:0] cap_ext;
	logic fit_open;
	logic fit_run;
	logic fit_plain;
	logic [7:0] dig_hi;
	logic [7:0] dig_lo;

	assign byte_in.ready = !q_stat.full;
	assign accept = byte_in.valid && byte_in.ready;

	assign printable = (byte_in.data_byte >= PRINT_LO) && (byte_in.data_byte <= PRINT_HI)
		&& (byte_in.data_byte != CH_LT);
	assign cap_ext = SUM_W'(capacity);
	assign count_p1 = count_q + COUNT_WIDTH'(1);
	// A plain byte after a run is checked after the closing '>' is counted.
	assign plain_base = hex_mode_q ? count_p1 : count_q;
	assign fit_open = (SUM_W'(count_q) + SUM_W'(5)) <= cap_ext;
	assign fit_run = (SUM_W'(count_q) + SUM_W'(4)) <= cap_ext;
	assign fit_plain = (SUM_W'(plain_base) + SUM_W'(2)) <= cap_ext;
	assign dig_hi = hex_digit(byte_in.data_byte[7:4]);
	assign dig_lo = hex_digit(byte_in.data_byte[3:0]);

	always_comb begin
		entry = '0;
		entry.status = ST_OK;
		hex_mode_d = hex_mode_q;
		overflowed_d = overflowed_q;
		count_d = count_q;
		if (byte_in.func == FUNC_END) begin
			if (!overflowed_q && hex_mode_q) begin
				entry.chars[0] = CH_GT;
				entry.chars[1] = CH_NUL;
				entry.num = 2'd2;
			end else begin
				entry.chars[0] = CH_NUL;
				entry.num = 2'd1;
			end
			entry.status = overflowed_q ? ST_OVERFLOW : ST_DONE;
			hex_mode_d = 1'b0;
			overflowed_d = 1'b0;
			count_d = '0;
		end else if (overflowed_q) begin
			entry.num = 2'd0;
		end else if (!printable) begin
			if (!hex_mode_q) begin
				if (!fit_open) begin
					overflowed_d = 1'b1;
				end else begin
					entry.chars[0] = CH_LT;
					entry.chars[1] = dig_hi;
					entry.chars[2] = dig_lo;
					entry.num = 2'd3;
					count_d = count_q + COUNT_WIDTH'(3);
					hex_mode_d = 1'b1;
				end
			end else if (!fit_run) begin
				overflowed_d = 1'b1;
			end else begin
				entry.chars[0] = dig_hi;
				entry.chars[1] = dig_lo;
				entry.num = 2'd2;
				count_d = count_q + COUNT_WIDTH'(2);
			end
		end else begin
			hex_mode_d = 1'b0;
			if (hex_mode_q) begin
				entry.chars[0] = CH_GT;
				entry.chars[1] = byte_in.data_byte;
				entry.num = fit_plain ? 2'd2 : 2'd1;
			end else begin
				entry.chars[0] = byte_in.data_byte;
				entry.num = fit_plain ? 2'd1 : 2'd0;
			end
			if (fit_plain) begin
				count_d = plain_base + COUNT_WIDTH'(1);
			end else begin
				count_d = plain_base;
				overflowed_d = 1'b1;
			end
		end
	end

	assign push = accept && (entry.num != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_mode_q <= 1'b0;
			overflowed_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			hex_mode_q <= hex_mode_d;
			overflowed_q <= overflowed_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== rtl/hexe_fifo.sv =====
// Short queue of character groups between the front and back ends.
// Uses hexe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hexe_fifo import hexe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input hexe_entry_t push_entry,
	input logic pop,
	output hexe_entry_t head,
	output hexe_qstat_t stat
);

	hexe_entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`HEXE_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= QCNT_W'(QUEUE_DEPTH))
	`HEXE_ASSERT_IMPLY(a_no_overrun, clk, arst_n, push, !stat.full || pop)
	`HEXE_ASSERT_IMPLY(a_no_underrun, clk, arst_n, pop, !stat.empty)

endmodule

// ===== rtl/hexe_back.sv =====
// Back end: walks the queued character groups and drives the output register one
// character per cycle when not stalled. Uses hexe_pkg, hexe_out_if, assert_macros.svh.
`include "assert_macros.svh"
module hexe_back import hexe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input hexe_entry_t head,
	input hexe_qstat_t q_stat,
	output logic pop,
	hexe_out_if.source char_out
);

	logic [1:0] idx_q;
	logic out_valid_q;
	logic [7:0] out_char_q;
	logic out_last_q;
	status_t out_status_q;

	logic load;
	logic is_last;

	assign load = !q_stat.empty && (!out_valid_q || char_out.ready);
	assign is_last = (idx_q == (head.num - 2'd1));
	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (char_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= head.chars[idx_q];
			out_last_q <= is_last;
			out_status_q <= is_last ? head.status : ST_OK;
		end
	end

	assign char_out.valid = out_valid_q;
	assign char_out.out_char = out_char_q;
	assign char_out.out_last = out_last_q;
	assign char_out.status = out_status_q;

	`HEXE_ASSERT_IMPLY(a_idx_in_group, clk, arst_n, !q_stat.empty, idx_q < head.num)
	`HEXE_ASSERT_IMPLY(a_idx_idle, clk, arst_n, q_stat.empty, idx_q == 2'd0)
	`HEXE_ASSERT_IMPLY(a_status_on_last, clk, arst_n, out_valid_q && !out_last_q, out_status_q == ST_OK)

endmodule

// ===== rtl/hex_escape_encoder_core.sv =====
// Top level of the hex escape encoder: APB capacity register, front end,
// queue and back end. Uses hexe_pkg, hexe_in_if, hexe_out_if and the submodules.
//
// The encoder turns a stream of binary bytes into text. A printable byte
// (0x21 to 0x7E, except '<') passes through as itself; any other byte becomes
// two upper-case hex digits, and a run of such bytes is enclosed in '<' and
// '>'. An end word (func = 1) closes an open run unless the buffer overflowed
// and emits a NUL, whose status is 1 when the buffer fit or 2 when it
// overflowed; every other character carries status 0, and out_last marks the
// final character of each input word. Before writing a byte the encoder checks
// its character count against the out_capacity register (5 needed to open a
// run, 4 inside a run, 2 for a plain byte); the first failing byte, but for
// the '>' that closes a run before it, and all later data bytes of the buffer
// emit nothing. The front end takes a new input word every cycle as long as
// its four-entry queue has room, and the back end sends one character per
// cycle while the receiver is ready; an input word yields one to three
// characters, none for a dropped byte. The single output port is what limits
// the flow. The first character of a word passes through the queue and the
// output register before it is on the output. out_capacity sits at byte
// address 0 of the APB port, resets to 65535 and should be written only while
// the encoder is idle; a new value applies from the next check on.
module hex_escape_encoder_core import hexe_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	hexe_in_if.sink byte_in,
	hexe_out_if.source char_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [CAP_W-1:0] capacity_q;
	logic cfg_write;
	logic push;
	logic pop;
	hexe_entry_t push_entry;
	hexe_entry_t head;
	hexe_qstat_t q_stat;

	// Registers sit on 32-bit words; paddr[2] selects the word.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// Front end: classification and buffer state, one word per cycle while the queue has room.
	hexe_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_in),
		.capacity(capacity_q),
		.q_stat(q_stat),
		.push(push),
		.entry(push_entry)
	);

	// Queue of character groups that decouples the two ends.
	hexe_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.stat(q_stat)
	);

	// Back end: serializes each group onto the output word by word.
	hexe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_stat(q_stat),
		.pop(pop),
		.char_out(char_out)
	);

endmodule

// ===== sim/tb_hex_escape_encoder_core.sv =====
// Self-checking testbench for hex_escape_encoder_core: drives byte words and
// capacity writes, predicts every text character and compares it on arrival.
// Depends on hexe_pkg, hexe_in_if, hexe_out_if and the encoder RTL.
module tb_hex_escape_encoder_core;
	import hexe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_W = 16;
	localparam int unsigned COUNT_MASK = (1 << COUNT_W) - 1;
	localparam int LIMIT_CYCLES = 200000;
	localparam int IDLE_PCT = 31;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [2:0] CAP_ADDR = {2'b00, REG_CAPACITY} << 2;

	// One predicted text character.
	typedef struct {
		logic [7:0] ch;
		logic last;
		status_t st;
	} text_char_t;

	// Holds the encoder's expected state and the characters it still owes.
	class char_scoreboard;
		int unsigned capacity = CAPACITY_RESET;
		bit in_run;
		int unsigned written;
		bit dropped;
		text_char_t owed_chars[$];
		int mismatches;
		int checked;

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		function void owe(logic [7:0] ch, status_t st);
			text_char_t c;
			c.ch = ch;
			c.last = 1'b0;
			c.st = st;
			owed_chars.push_back(c);
		endfunction

		function bit room_for(int unsigned need);
			return written + need <= capacity;
		endfunction

		// Works out the characters that one accepted word will produce.
		function void note_input(logic [0:0] f, logic [7:0] b);
			int n0;
			bit plain;
			bit digits;
			n0 = owed_chars.size();
			plain = (b >= PRINT_LO) && (b <= PRINT_HI) && (b != CH_LT);
			digits = 1'b0;
			if (f == FUNC_END) begin
				if (!dropped && in_run) begin
					owe(CH_GT, ST_OK);
				end
				owe(CH_NUL, dropped ? ST_OVERFLOW : ST_DONE);
				in_run = 1'b0;
				written = 0;
				dropped = 1'b0;
			end else if (dropped) begin
				// The buffer already overflowed, so the byte is swallowed.
			end else if (!plain) begin
				if (!in_run) begin
					if (!room_for(5)) begin
						dropped = 1'b1;
					end else begin
						owe(CH_LT, ST_OK);
						written = (written + 1) & COUNT_MASK;
						in_run = 1'b1;
						digits = 1'b1;
					end
				end else if (!room_for(4)) begin
					dropped = 1'b1;
				end else begin
					digits = 1'b1;
				end
				if (digits) begin
					owe(nibble_char(b[7:4]), ST_OK);
					owe(nibble_char(b[3:0]), ST_OK);
					written = (written + 2) & COUNT_MASK;
				end
			end else begin
				// The closing bracket goes out before the plain byte is checked.
				if (in_run) begin
					owe(CH_GT, ST_OK);
					written = (written + 1) & COUNT_MASK;
					in_run = 1'b0;
				end
				if (!room_for(2)) begin
					dropped = 1'b1;
				end else begin
					owe(b, ST_OK);
					written = (written + 1) & COUNT_MASK;
				end
			end
			if (owed_chars.size() > n0) begin
				owed_chars[owed_chars.size() - 1].last = 1'b1;
			end
		endfunction

		function logic [7:0] nibble_char(logic [3:0] nib);
			if (nib < 4'd10) begin
				return CH_ZERO + 8'(nib);
			end
			return CH_A - 8'd10 + 8'(nib);
		endfunction

		// Compares one delivered character with the oldest one owed.
		function void check_result(logic [7:0] ch, logic last, logic [1:0] st);
			text_char_t e;
			checked++;
			if (owed_chars.size() == 0) begin
				flag($sformatf("unexpected char %02h last %0d status %0d", ch, last, st));
				return;
			end
			e = owed_chars.pop_front();
			if (ch !== e.ch || last !== e.last || st !== e.st) begin
				flag($sformatf("char %02h/%02h last %0d/%0d status %0d/%0d (exp/got)",
					e.ch, ch, e.last, last, e.st, st));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	hexe_in_if in_ch();
	hexe_out_if out_ch();

	char_scoreboard sb = new();

	// While calm is set neither side inserts idle cycles.
	bit calm;
	int cycle_count;
	int words_sent;
	int cap_settings;

	hex_escape_encoder_core #(.COUNT_WIDTH(COUNT_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(in_ch),
		.char_out(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random; it changes its mind only at falling edges.
	always @(negedge clk) begin
		out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// All handshakes are observed at the rising edge. Inputs are noted before
	// outputs are checked, so a same-edge dependency would still be ordered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(in_ch.func, in_ch.data_byte);
				words_sent++;
			end
			if (out_ch.valid && out_ch.ready) begin
				sb.check_result(out_ch.out_char, out_ch.out_last, out_ch.status);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offers one word, starting at a falling edge, and returns at the falling
	// edge after it was accepted. Valid stays high into the next word unless
	// the random idle roll drops it.
	task automatic send_word(logic [0:0] f, logic [7:0] b);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= f;
		in_ch.data_byte <= b;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Stops the input side and waits until every owed character has arrived,
	// then waits on for any dropped byte still in flight.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.owed_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Writes out_capacity over APB and reads it back. Called only while idle.
	task automatic set_capacity(logic [CAP_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CAP_ADDR;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		sb.capacity = value;
		cap_settings++;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		if (prdata[CAP_W-1:0] !== value) begin
			sb.flag($sformatf("capacity readback %04h, wrote %04h", prdata[CAP_W-1:0], value));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random byte that leans toward the class boundaries: plain text, bytes
	// that need escaping, the '<' that must be escaped, and anything at all.
	function automatic logic [7:0] pick_byte();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			return 8'($urandom_range(PRINT_LO, PRINT_HI));
		end else if (kind < 6) begin
			return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8'h20))
				: 8'($urandom_range(8'h7F, 8'hFF));
		end else if (kind == 6) begin
			return CH_LT;
		end
		return 8'($urandom);
	endfunction

	initial begin
		logic [CAP_W-1:0] cap;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_DATA;
		in_ch.data_byte = 8'h00;
		out_ch.ready = 1'b0;
		calm = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset capacity: both ends of the printable range,
		// a plain '>', the escaped '<', a run over the byte extremes, a plain byte
		// that closes the run, another run closed by an end word, and an end word
		// on an empty buffer.
		send_word(FUNC_DATA, PRINT_LO);
		send_word(FUNC_DATA, PRINT_HI);
		send_word(FUNC_DATA, CH_GT);
		send_word(FUNC_DATA, CH_LT);
		send_word(FUNC_DATA, 8'h00);
		send_word(FUNC_DATA, 8'hFF);
		send_word(FUNC_DATA, CH_A);
		send_word(FUNC_DATA, 8'h20);
		send_word(FUNC_DATA, 8'h7F);
		send_word(FUNC_END, 8'h00);
		send_word(FUNC_END, 8'hFF);
		settle();

		// Capacity 6: the run opens, the second escaped byte overflows, and the
		// plain byte after it is swallowed.
		set_capacity(16'd6);
		send_word(FUNC_DATA, 8'h00);
		send_word(FUNC_DATA, 8'h01);
		send_word(FUNC_DATA, CH_A);
		send_word(FUNC_END, 8'h00);
		settle();

		// Capacity 5: a plain byte after a run gets only the closing '>'.
		set_capacity(16'd5);
		send_word(FUNC_DATA, 8'h80);
		send_word(FUNC_DATA, 8'h42);
		send_word(FUNC_END, 8'h00);
		settle();

		// Capacity 0: an empty buffer still ends cleanly, a byte then overflows.
		set_capacity(16'd0);
		send_word(FUNC_END, 8'h55);
		send_word(FUNC_DATA, CH_A);
		send_word(FUNC_END, 8'hAA);
		settle();

		// Capacity 3: two plain bytes fit, a run cannot open.
		set_capacity(16'd3);
		send_word(FUNC_DATA, CH_A);
		send_word(FUNC_DATA, 8'h42);
		send_word(FUNC_DATA, 8'h00);
		send_word(FUNC_END, 8'h00);
		settle();

		// Random part: five phases of fifteen words, each with its own capacity.
		// The third phase runs with no idle cycles on either side.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: cap = CAPACITY_RESET;
				1: cap = 16'($urandom_range(0, 12));
				2: cap = 16'($urandom_range(13, 80));
				3: cap = 16'($urandom);
				default: cap = 16'($urandom_range(6, 30));
			endcase
			set_capacity(cap);
			calm = (p == 2);
			for (int i = 0; i < 15; i++) begin
				if ($urandom_range(0, 7) == 0) begin
					send_word(FUNC_END, 8'($urandom));
				end else begin
					send_word(FUNC_DATA, pick_byte());
				end
			end
			calm = 1'b0;
			settle();
		end

		// Close whatever buffer is open at the largest capacity.
		set_capacity(CAPACITY_RESET);
		send_word(FUNC_END, 8'($urandom));
		settle();

		if (sb.owed_chars.size() != 0) begin
			sb.flag($sformatf("%0d characters never arrived", sb.owed_chars.size()));
		end
		$display("Sent %0d words and checked %0d characters across %0d capacity settings.",
			words_sent, sb.checked, cap_settings);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hexe_pkg.sv
rtl/hexe_in_if.sv
rtl/hexe_out_if.sv
rtl/hexe_front.sv
rtl/hexe_fifo.sv
rtl/hexe_back.sv
rtl/hex_escape_encoder_core.sv
sim/tb_hex_escape_encoder_core.sv
